### hdl/x86_rotate_unit_assert.svh
// ---------------------------------------------------------------------------
// x86_rotate_unit_assert.svh
// Assertion macros shared by the rotate unit checker.
// ---------------------------------------------------------------------------
`ifndef X86_ROTATE_UNIT_ASSERT_SVH
`define X86_ROTATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotate unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define XRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotate unit assertion failed");

`endif

### hdl/xru_pkg.sv
// ---------------------------------------------------------------------------
// xru_pkg
// Types, codes and helper functions for the x86 rotate unit.
// ---------------------------------------------------------------------------
`default_nettype none

package xru_pkg;

    // Rotate operation codes.
    typedef enum logic [1:0] {
        CMD_RCL = 2'd0,
        CMD_RCR = 2'd1,
        CMD_ROL = 2'd2,
        CMD_ROR = 2'd3
    } cmd_t;

    // Operand size codes.
    typedef enum logic [1:0] {
        SZ_8  = 2'd0,
        SZ_16 = 2'd1,
        SZ_32 = 2'd2,
        SZ_64 = 2'd3
    } size_t;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned COUNT_W = 8;

    // One rotate request as it travels to the datapath.
    typedef struct packed {
        cmd_t                cmd;
        size_t               size;
        logic [DATA_W-1:0]   operand;
        logic [COUNT_W-1:0]  count;
        logic                carry;
        logic                overflow;
    } rot_req_t;

    // One rotate outcome.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              carry;
        logic              overflow;
    } rot_rsp_t;

    // Operand width in bits for a size code.
    function automatic logic [6:0] size_width(input size_t sz);
        logic [6:0] w;
        case (sz)
            SZ_8:    w = 7'd8;
            SZ_16:   w = 7'd16;
            SZ_32:   w = 7'd32;
            default: w = 7'd64;
        endcase
        return w;
    endfunction

    // Mask covering the operand width.
    function automatic logic [DATA_W-1:0] size_mask(input size_t sz);
        logic [DATA_W-1:0] m;
        case (sz)
            SZ_8:    m = 64'h0000_0000_0000_00FF;
            SZ_16:   m = 64'h0000_0000_0000_FFFF;
            SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Most significant bit of the operand width.
    function automatic logic size_msb(input size_t sz, input logic [DATA_W-1:0] v);
        logic b;
        case (sz)
            SZ_8:    b = v[7];
            SZ_16:   b = v[15];
            SZ_32:   b = v[31];
            default: b = v[63];
        endcase
        return b;
    endfunction

    // Second most significant bit of the operand width.
    function automatic logic size_second(input size_t sz, input logic [DATA_W-1:0] v);
        logic b;
        case (sz)
            SZ_8:    b = v[6];
            SZ_16:   b = v[14];
            SZ_32:   b = v[30];
            default: b = v[62];
        endcase
        return b;
    endfunction

    // Count reduction for rotates through carry: modulo 9 or 17 on the
    // narrow sizes, where the masked count can exceed the ring length.
    function automatic logic [5:0] rc_reduce(input size_t sz, input logic [5:0] n);
        logic [5:0] r;
        case (sz)
            SZ_8:
            begin
                if (n >= 6'd27)
                    r = n - 6'd27;
                else if (n >= 6'd18)
                    r = n - 6'd18;
                else if (n >= 6'd9)
                    r = n - 6'd9;
                else
                    r = n;
            end
            SZ_16:
            begin
                if (n >= 6'd17)
                    r = n - 6'd17;
                else
                    r = n;
            end
            default: r = n;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/xru_rotator.sv
// ---------------------------------------------------------------------------
// xru_rotator
// Combinational rotate datapath: one variable-length ring rotator serves
// all four operations, with the carry folded into the ring for RCL and RCR.
// ---------------------------------------------------------------------------
`default_nettype none

module xru_rotator (
    input  xru_pkg::rot_req_t req,
    output xru_pkg::rot_rsp_t rsp
);

    logic [6:0]  width;
    logic [63:0] wmask;
    logic [63:0] val;
    logic [5:0]  cnt_masked;
    logic [5:0]  cnt_mod;
    logic [5:0]  cnt_eff;
    logic        thru_carry;
    logic [6:0]  ring_len;
    logic [64:0] ring;
    logic [64:0] ring_mask;
    logic [6:0]  lamt;
    logic [64:0] rot;
    logic [63:0] rot_val;
    logic        msb_in;
    logic        msb_out;
    logic        second_out;
    logic        carry_new;
    logic        of_new;

    // Operand width, masking and count preparation.
    always_comb
    begin
        width      = xru_pkg::size_width(req.size);
        wmask      = xru_pkg::size_mask(req.size);
        val        = req.operand & wmask;
        cnt_masked = (req.size == xru_pkg::SZ_64) ? req.count[5:0]
                                                  : {1'b0, req.count[4:0]};
        cnt_mod    = cnt_masked & 6'(width - 7'd1);
        thru_carry = (req.cmd == xru_pkg::CMD_RCL) || (req.cmd == xru_pkg::CMD_RCR);
        cnt_eff    = thru_carry ? xru_pkg::rc_reduce(req.size, cnt_masked) : cnt_masked;
    end

    // Build the ring and express every operation as a left rotation.
    always_comb
    begin
        ring     = {1'b0, val};
        ring_len = width;
        if (thru_carry)
        begin
            ring     = ring | (65'(req.carry) << width);
            ring_len = width + 7'd1;
        end

        case (req.cmd)
            xru_pkg::CMD_RCL: lamt = {1'b0, cnt_eff};
            xru_pkg::CMD_RCR: lamt = (cnt_eff == 6'd0) ? 7'd0 : ring_len - {1'b0, cnt_eff};
            xru_pkg::CMD_ROL: lamt = {1'b0, cnt_mod};
            xru_pkg::CMD_ROR: lamt = (cnt_mod == 6'd0) ? 7'd0 : width - {1'b0, cnt_mod};
            default:          lamt = 7'd0;
        endcase

        ring_mask = (65'd1 << ring_len) - 65'd1;
        rot       = ((ring << lamt) | (ring >> (ring_len - lamt))) & ring_mask;
        rot_val   = rot[63:0] & wmask;
    end

    // Flag generation.
    always_comb
    begin
        msb_in     = xru_pkg::size_msb(req.size, val);
        msb_out    = xru_pkg::size_msb(req.size, rot_val);
        second_out = xru_pkg::size_second(req.size, rot_val);

        case (req.cmd)
            xru_pkg::CMD_RCL,
            xru_pkg::CMD_RCR: carry_new = rot[width];
            xru_pkg::CMD_ROL: carry_new = rot_val[0];
            default:          carry_new = msb_out;
        endcase

        of_new = 1'b0;
        if (cnt_eff == 6'd1)
        begin
            case (req.cmd)
                xru_pkg::CMD_RCL: of_new = msb_out ^ carry_new;
                xru_pkg::CMD_RCR: of_new = msb_in ^ req.carry;
                xru_pkg::CMD_ROL: of_new = msb_out ^ carry_new;
                default:          of_new = msb_out ^ second_out;
            endcase
        end
    end

    // A zero effective count leaves value and flags untouched.
    always_comb
    begin
        if (cnt_eff == 6'd0)
        begin
            rsp.value    = val;
            rsp.carry    = req.carry;
            rsp.overflow = req.overflow;
        end
        else
        begin
            rsp.value    = rot_val;
            rsp.carry    = carry_new;
            rsp.overflow = of_new;
        end
    end

endmodule

`default_nettype wire

### hdl/x86_rotate_unit.sv
// ---------------------------------------------------------------------------
// x86_rotate_unit
// Executes one x86 RCL, RCR, ROL or ROR on an 8, 16, 32 or 64 bit operand.
// ---------------------------------------------------------------------------
//  Channel   | Signals                                          | Handshake
//  ----------+--------------------------------------------------+-------------------
//  request   | command size_code operand count carry_in         | start && !busy
//            | overflow_in                                      |
//  result    | result carry_out overflow_out                    | done, one cycle
//
// A request is taken in every cycle; busy is never raised.
// Each result passes through the input register, then through the
// single-pass rotator into the result register.
// The rotator is one ring shifter, so the rate is one request per clock.
// Reset clears the valid flags only; no request in flight survives it.
// The receiver cannot stall, so no result is ever held back.
// ---------------------------------------------------------------------------
`default_nettype none

module x86_rotate_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [1:0]  size_code,
    input  wire logic [63:0] operand,
    input  wire logic [7:0]  count,
    input  wire logic        carry_in,
    input  wire logic        overflow_in,
    output logic             done,
    output logic [63:0]      result,
    output logic             carry_out,
    output logic             overflow_out
);

    xru_pkg::rot_req_t req_reg;
    xru_pkg::rot_req_t req_next;
    logic              req_valid_reg;
    xru_pkg::rot_rsp_t rsp_reg;
    xru_pkg::rot_rsp_t rsp_next;
    logic              done_reg;

    // The datapath never blocks a new request.
    assign busy = 1'b0;

    // Pack the request ports.
    always_comb
    begin
        req_next.cmd      = xru_pkg::cmd_t'(command);
        req_next.size     = xru_pkg::size_t'(size_code);
        req_next.operand  = operand;
        req_next.count    = count;
        req_next.carry    = carry_in;
        req_next.overflow = overflow_in;
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req_next;
    end

    // Single-pass rotate datapath.
    xru_rotator u_rotator (
        .req (req_reg),
        .rsp (rsp_next)
    );

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign done         = done_reg;
    assign result       = rsp_reg.value;
    assign carry_out    = rsp_reg.carry;
    assign overflow_out = rsp_reg.overflow;

endmodule

`default_nettype wire

### hdl/xru_checker.sv
// ---------------------------------------------------------------------------
// xru_checker
// Port-level checks on the rotate unit's request and result timing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "x86_rotate_unit_assert.svh"

module xru_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [7:0]  count,
    input wire logic        carry_in,
    input wire logic        overflow_in,
    input wire logic        done,
    input wire logic        carry_out,
    input wire logic        overflow_out
);

    logic accept;
    logic zero_accept;

    assign accept      = start && !busy;
    assign zero_accept = accept && (count[5:0] == 6'd0);

    // Every accepted request yields a result through the input and result registers.
    `XRU_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, ##1 done)

    // No result appears without a request accepted ahead of it through both registers.
    `XRU_ASSERT_IMPL(a_no_spurious, clk, rst_n, done, $past(accept, 2))

    // A zero masked count passes both flags through unchanged.
    `XRU_ASSERT_NEXT(a_zero_flags, clk, rst_n, zero_accept,
        ##1 (carry_out == $past(carry_in, 2) && overflow_out == $past(overflow_in, 2)))

    // Back-to-back results come only from back-to-back requests.
    `XRU_ASSERT_IMPL(a_streaming, clk, rst_n, done && $past(done),
        $past(accept, 2) && $past(accept, 3))

endmodule

bind x86_rotate_unit xru_checker u_xru_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .count        (count),
    .carry_in     (carry_in),
    .overflow_in  (overflow_in),
    .done         (done),
    .carry_out    (carry_out),
    .overflow_out (overflow_out)
);

`default_nettype wire

### tb/x86_rotate_unit_tb.sv
// ---------------------------------------------------------------------------
// x86_rotate_unit_tb
// Self-checking testbench for the x86 rotate unit.
//
// Requests of all four rotates and all four operand sizes are sent through
// the start/busy handshake. Directed requests cover zero and unit counts and
// the count masking and reduction boundaries. These are followed by about
// 630 random requests. A bit-level rotate predictor queues the expected
// outcome of each accepted request. A checker compares every done strobe
// against the oldest expectation, field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module x86_rotate_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_REQUESTS = 630;
    localparam int unsigned IDLE_LIMIT      = 200;
    localparam int unsigned DRAIN_CYCLES    = 4;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    xru_pkg::cmd_t   command = xru_pkg::CMD_RCL;
    xru_pkg::size_t  size_code = xru_pkg::SZ_8;
    logic [63:0]     operand = '0;
    logic [7:0]      count = '0;
    logic            carry_in = 1'b0;
    logic            overflow_in = 1'b0;
    logic            busy;
    logic            done;
    logic [63:0]     result;
    logic            carry_out;
    logic            overflow_out;

    xru_pkg::rot_rsp_t pending_results[$];
    int unsigned       error_count = 0;
    int unsigned       idle_cycles = 0;
    bit                back_to_back = 1'b0;

    x86_rotate_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .size_code    (size_code),
        .operand      (operand),
        .count        (count),
        .carry_in     (carry_in),
        .overflow_in  (overflow_in),
        .done         (done),
        .result       (result),
        .carry_out    (carry_out),
        .overflow_out (overflow_out)
    );

    always #5 clk = ~clk;

    // Bit-serial rotate: the count is masked and reduced, then the value is
    // stepped one position at a time, with the flags following the x86 rules.
    function automatic xru_pkg::rot_rsp_t predict_rotate(xru_pkg::cmd_t op,
                                                         xru_pkg::size_t sz,
                                                         logic [63:0] val,
                                                         logic [7:0] raw_count,
                                                         logic cf, logic of);
        int unsigned       width;
        int unsigned       steps;
        logic [63:0]       keep;
        logic [63:0]       top;
        logic [63:0]       v;
        logic              shifted_out;
        xru_pkg::rot_rsp_t outcome;
        width = 8 << sz;
        keep  = (width == 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
        top   = 64'd1 << (width - 1);
        v     = val & keep;
        steps = (width == 64) ? 32'(raw_count[5:0]) : 32'(raw_count[4:0]);
        if (op == xru_pkg::CMD_RCL || op == xru_pkg::CMD_RCR)
        begin
            if (width == 8)
                steps = steps % 9;
            else if (width == 16)
                steps = steps % 17;
        end
        if (steps != 0)
        begin
            of = 1'b0;
            case (op)
                xru_pkg::CMD_RCL:
                begin
                    for (int i = 0; i < steps; i++)
                    begin
                        shifted_out = (v & top) != 0;
                        v  = ((v << 1) | 64'(cf)) & keep;
                        cf = shifted_out;
                    end
                    if (steps == 1)
                        of = ((v & top) != 0) ^ cf;
                end
                xru_pkg::CMD_RCR:
                begin
                    if (steps == 1)
                        of = ((v & top) != 0) ^ cf;
                    for (int i = 0; i < steps; i++)
                    begin
                        shifted_out = v[0];
                        v  = (v >> 1) | (cf ? top : 64'd0);
                        cf = shifted_out;
                    end
                end
                xru_pkg::CMD_ROL:
                begin
                    for (int i = 0; i < steps; i++)
                        v = ((v << 1) | 64'((v & top) != 0)) & keep;
                    cf = v[0];
                    if (steps == 1)
                        of = ((v & top) != 0) ^ cf;
                end
                default:
                begin
                    for (int i = 0; i < steps; i++)
                        v = (v >> 1) | (v[0] ? top : 64'd0);
                    cf = (v & top) != 0;
                    if (steps == 1)
                        of = cf ^ ((v & (top >> 1)) != 0);
                end
            endcase
        end
        outcome.value    = v & keep;
        outcome.carry    = cf;
        outcome.overflow = of;
        return outcome;
    endfunction

    // One line per mismatch; the count decides the final verdict.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("%0t ns: MISMATCH %s: got 0x%016h, expected 0x%016h", $time, what, got, want);
    endtask

    // Send one request after a random pause (none in back-to-back mode), then hold it until it is taken.
    task automatic send_request(xru_pkg::cmd_t op, xru_pkg::size_t sz, logic [63:0] val,
                                logic [7:0] cnt, logic cf, logic of);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command     <= op;
        size_code   <= sz;
        operand     <= val;
        count       <= cnt;
        carry_in    <= cf;
        overflow_in <= of;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_rotate(op, sz, val, cnt, cf, of));
    endtask

    // Counts that mask or reduce to zero must pass value and flags through.
    task automatic test_zero_count();
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_8,  64'hFFFF_FFFF_FFFF_FFFF, 8'd0,
                     1'b1, 1'b1);
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_8,  64'hDEAD_BEEF_0000_00A5, 8'd9,
                     1'b0, 1'b1);
        send_request(xru_pkg::CMD_RCR, xru_pkg::SZ_16, 64'hFFFF_FFFF_FFFF_8001, 8'd17,
                     1'b1, 1'b1);
        send_request(xru_pkg::CMD_ROL, xru_pkg::SZ_8,  64'h0123_4567_89AB_CDEF, 8'd32,
                     1'b1, 1'b0);
        send_request(xru_pkg::CMD_ROR, xru_pkg::SZ_64, 64'h8000_0000_0000_0001, 8'd64,
                     1'b0, 1'b1);
        send_request(xru_pkg::CMD_ROR, xru_pkg::SZ_32, 64'hFFFF_FFFF_FFFF_FFFF, 8'd224,
                     1'b1, 1'b1);
    endtask

    // A count of one is the only case that sets overflow.
    task automatic test_count_one();
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_8,  64'h0000_0000_0000_0040, 8'd1,
                     1'b0, 1'b0);
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_64, 64'h8000_0000_0000_0000, 8'd1,
                     1'b1, 1'b0);
        send_request(xru_pkg::CMD_RCR, xru_pkg::SZ_16, 64'h0000_0000_0000_8000, 8'd1,
                     1'b0, 1'b0);
        send_request(xru_pkg::CMD_RCR, xru_pkg::SZ_32, 64'h0000_0000_0000_0001, 8'd1,
                     1'b1, 1'b0);
        send_request(xru_pkg::CMD_ROL, xru_pkg::SZ_32, 64'h0000_0000_4000_0000, 8'd1,
                     1'b0, 1'b0);
        send_request(xru_pkg::CMD_ROL, xru_pkg::SZ_64, 64'hC000_0000_0000_0000, 8'd1,
                     1'b0, 1'b1);
        send_request(xru_pkg::CMD_ROR, xru_pkg::SZ_8,  64'h0000_0000_0000_0001, 8'd1,
                     1'b0, 1'b0);
        send_request(xru_pkg::CMD_ROR, xru_pkg::SZ_16, 64'h0000_0000_0000_0003, 8'd1,
                     1'b1, 1'b1);
    endtask

    // Largest masked counts and the edges of the modulo 9 and 17 rings.
    task automatic test_reduction_bounds();
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_8,  64'h0000_0000_0000_0081, 8'd31,
                     1'b1, 1'b1);
        send_request(xru_pkg::CMD_RCR, xru_pkg::SZ_8,  64'h0000_0000_0000_00FF, 8'd8,
                     1'b0, 1'b1);
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_8,  64'h0000_0000_0000_0000, 8'd27,
                     1'b1, 1'b0);
        send_request(xru_pkg::CMD_RCR, xru_pkg::SZ_16, 64'h0000_0000_0000_1234, 8'd16,
                     1'b1, 1'b0);
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_16, 64'h0000_0000_0000_FFFF, 8'd18,
                     1'b0, 1'b1);
        send_request(xru_pkg::CMD_ROR, xru_pkg::SZ_64, 64'hFFFF_FFFF_FFFF_FFFF, 8'd63,
                     1'b0, 1'b1);
        send_request(xru_pkg::CMD_ROL, xru_pkg::SZ_32, 64'h8000_0000_0000_0001, 8'd255,
                     1'b1, 1'b1);
        send_request(xru_pkg::CMD_RCL, xru_pkg::SZ_64, 64'h0000_0000_0000_0000, 8'd63,
                     1'b1, 1'b0);
    endtask

    // Random requests; bursts without pauses alternate with paced stretches.
    task automatic test_random_mix();
        logic [63:0] val;
        logic [7:0]  cnt;
        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++)
        begin
            back_to_back = ((n / 40) % 3) == 1;
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = {64{1'b1}};
                2:       val = 64'd1 << $urandom_range(0, 63);
                default: val = {$urandom, $urandom};
            endcase
            // Small counts are favoured so that the count-of-one rules are hit often.
            cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
            send_request(xru_pkg::cmd_t'($urandom_range(0, 3)),
                         xru_pkg::size_t'($urandom_range(0, 3)),
                         val, cnt, 1'($urandom), 1'($urandom));
        end
        back_to_back = 1'b0;
    endtask

    // Every done strobe is matched against the oldest outstanding request.
    always @(posedge clk)
    begin
        xru_pkg::rot_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding", result, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.value)
                    report_mismatch("result", result, want.value);
                if (carry_out !== want.carry)
                    report_mismatch("carry_out", 64'(carry_out), 64'(want.carry));
                if (overflow_out !== want.overflow)
                    report_mismatch("overflow_out", 64'(overflow_out), 64'(want.overflow));
            end
        end
    end

    // The run is abandoned when neither side moves for too long.
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("x86_rotate_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_count();
        test_count_one();
        test_reduction_bounds();
        test_random_mix();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("x86_rotate_unit verification clean");
        else
            $display("x86_rotate_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
